FILE: design/wpm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types, widths, character codes and helpers for the word pattern
// matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int PATTERN_BYTES_DEF = 56;
    localparam int OFFSET_BITS_DEF   = 16;

    localparam int CUR_W      = 6;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int START_W    = 16;
    localparam int BYTE_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LEN_INDEX = 3'd7;

    localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CARET   = 8'h5E;
    localparam logic [BYTE_W-1:0] CH_RBRACK  = 8'h5D;
    localparam logic [BYTE_W-1:0] CH_BSLASH  = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;

    localparam logic [CUR_W-1:0] WORD_LEN_MAX = 6'd63;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ELEM,
        ST_NEG,
        ST_SET,
        ST_ESC
    } wpm_state_t;

    function automatic logic is_space(input logic [BYTE_W-1:0] b);
        return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    endfunction

endpackage

FILE: design/wpm_pattern_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pattern_store
// Holds the pattern registers and the pattern length, and serves one pattern
// byte per cycle to the matching sequencer.
// ----------------------------------------------------------------------------
module wpm_pattern_store #(
    parameter int PATTERN_BYTES = wpm_pkg::PATTERN_BYTES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [wpm_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [wpm_pkg::CFG_DATA_W-1:0] wr_data,
    input  logic [wpm_pkg::CUR_W-1:0]      rd_idx,
    output logic [wpm_pkg::BYTE_W-1:0]     rd_byte,
    output logic [wpm_pkg::CUR_W-1:0]      pat_len
);
    import wpm_pkg::*;

    localparam int ROWS  = (PATTERN_BYTES + 7) / 8;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [CFG_DATA_W-1:0] rows_reg [ROWS];
    logic [CUR_W-1:0]      len_reg;
    logic [2:0]            rd_row;
    logic [CFG_DATA_W-1:0] row_data;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < ROWS; i++) begin
                rows_reg[i] <= '0;
            end
            len_reg <= '0;
        end else if (wr_en) begin
            if (wr_index == CFG_LEN_INDEX) begin
                len_reg <= wr_data[CUR_W-1:0];
            end else if ({1'b0, wr_index} < 4'(ROWS)) begin
                rows_reg[wr_index[ROW_W-1:0]] <= wr_data;
            end
        end
    end

    assign rd_row   = rd_idx[5:3];
    assign row_data = rows_reg[rd_row[ROW_W-1:0]];

    always_comb begin
        if (rd_idx < CUR_W'(PATTERN_BYTES)) begin
            rd_byte = row_data[{rd_idx[2:0], 3'b000} +: BYTE_W];
        end else begin
            rd_byte = '0;
        end
    end

    assign pat_len = (len_reg > CUR_W'(PATTERN_BYTES)) ? CUR_W'(PATTERN_BYTES) : len_reg;

endmodule

FILE: design/word_pattern_matcher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_pattern_matcher_top
// Splits a byte stream into words and reports the first word of each text
// that fits the configured pattern, or a not-found result if none fits.
// ----------------------------------------------------------------------------
// Usage:
// Text bytes enter on the input channel (in_valid / in_stall), one byte or
// one end-of-text marker per transaction. Results leave on the output channel
// (out_valid / out_stall) as one registered transaction: found, word_start
// and word_length. The pattern is written through the configuration channel
// (cfg_valid / cfg_ready, always ready) while the block is idle.
// Whitespace bytes, end markers and bytes that need no pattern test are
// handled in ST_IDLE alone. A byte tested against a pattern element also
// passes ST_ELEM, then ST_ESC for an escape or ST_NEG and ST_SET for a
// bracket set, and the input channel is stalled until ST_IDLE returns; the
// single pattern byte read port and comparator decide this. A result appears
// in the cycle after the whitespace byte or end marker that causes it.
// Reset clears the pattern and the text state. While the output register
// holds a result that is stalled, the input channel is stalled as well.
// ----------------------------------------------------------------------------
module word_pattern_matcher_top #(
    parameter int PATTERN_BYTES = wpm_pkg::PATTERN_BYTES_DEF,
    parameter int OFFSET_BITS   = wpm_pkg::OFFSET_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [wpm_pkg::BYTE_W-1:0]     text_byte,
    input  logic                           end_of_text,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           found,
    output logic [wpm_pkg::START_W-1:0]    word_start,
    output logic [wpm_pkg::CUR_W-1:0]      word_length,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wpm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import wpm_pkg::*;

    wpm_state_t state_reg, state_next;

    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [CUR_W-1:0]       wlen_reg, wlen_next;
    logic [CUR_W-1:0]       cursor_reg, cursor_next;
    logic                   still_reg, still_next;
    logic                   inside_reg, inside_next;
    logic                   reported_reg, reported_next;

    logic [CUR_W-1:0]       j_reg, j_next;
    logic [BYTE_W-1:0]      b_reg, b_next;
    logic                   neg_reg, neg_next;
    logic                   hit_reg, hit_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   found_reg, found_next;
    logic [START_W-1:0]     ostart_reg, ostart_next;
    logic [CUR_W-1:0]       olen_reg, olen_next;

    logic [BYTE_W-1:0]      rd_byte;
    logic [CUR_W-1:0]       pat_len;
    logic                   in_accept;
    logic                   word_match;
    logic [OFFSET_BITS+START_W-1:0] start_ext;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign word_start  = ostart_reg;
    assign word_length = olen_reg;

    assign start_ext  = {{START_W{1'b0}}, start_reg};
    assign word_match = inside_reg && still_reg && (cursor_reg == pat_len);

    wpm_pattern_store #(
        .PATTERN_BYTES(PATTERN_BYTES)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_index(cfg_index),
        .wr_data (cfg_data),
        .rd_idx  (j_reg),
        .rd_byte (rd_byte),
        .pat_len (pat_len)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            start_reg     <= '0;
            wlen_reg      <= '0;
            cursor_reg    <= '0;
            still_reg     <= 1'b1;
            inside_reg    <= 1'b0;
            reported_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            wlen_reg      <= wlen_next;
            cursor_reg    <= cursor_next;
            still_reg     <= still_next;
            inside_reg    <= inside_next;
            reported_reg  <= reported_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        j_reg      <= j_next;
        b_reg      <= b_next;
        neg_reg    <= neg_next;
        hit_reg    <= hit_next;
        found_reg  <= found_next;
        ostart_reg <= ostart_next;
        olen_reg   <= olen_next;
    end

    always_comb begin
        logic             fresh_still;
        logic [CUR_W-1:0] fresh_cursor;
        logic [CUR_W-1:0] fresh_len;
        logic             elem_done;
        logic             elem_ok;
        logic [CUR_W-1:0] elem_next;

        state_next     = state_reg;
        pos_next       = pos_reg;
        start_next     = start_reg;
        wlen_next      = wlen_reg;
        cursor_next    = cursor_reg;
        still_next     = still_reg;
        inside_next    = inside_reg;
        reported_next  = reported_reg;
        j_next         = j_reg;
        b_next         = b_reg;
        neg_next       = neg_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && out_stall;
        found_next     = found_reg;
        ostart_next    = ostart_reg;
        olen_next      = olen_reg;
        fresh_still    = inside_reg ? still_reg : 1'b1;
        fresh_cursor   = inside_reg ? cursor_reg : '0;
        fresh_len      = inside_reg ? wlen_reg : '0;
        elem_done      = 1'b0;
        elem_ok        = 1'b0;
        elem_next      = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (end_of_text) begin
                        if (!reported_reg) begin
                            out_valid_next = 1'b1;
                            found_next     = word_match;
                            ostart_next    = word_match ? start_ext[START_W-1:0] : '0;
                            olen_next      = word_match ? wlen_reg : '0;
                        end
                        pos_next      = '0;
                        start_next    = '0;
                        wlen_next     = '0;
                        cursor_next   = '0;
                        still_next    = 1'b1;
                        inside_next   = 1'b0;
                        reported_next = 1'b0;
                    end else begin
                        if (is_space(text_byte)) begin
                            if (inside_reg) begin
                                if (!reported_reg && word_match) begin
                                    out_valid_next = 1'b1;
                                    found_next     = 1'b1;
                                    ostart_next    = start_ext[START_W-1:0];
                                    olen_next      = wlen_reg;
                                    reported_next  = 1'b1;
                                end
                                inside_next = 1'b0;
                            end
                        end else begin
                            if (!inside_reg) begin
                                inside_next = 1'b1;
                                start_next  = pos_reg;
                            end
                            wlen_next   = (fresh_len < WORD_LEN_MAX) ? fresh_len + 1'b1
                                                                     : fresh_len;
                            cursor_next = fresh_cursor;
                            still_next  = fresh_still;
                            if (fresh_still) begin
                                if (fresh_cursor >= pat_len) begin
                                    still_next = 1'b0;
                                end else begin
                                    j_next     = fresh_cursor;
                                    b_next     = text_byte;
                                    state_next = ST_ELEM;
                                end
                            end
                        end
                        if (pos_reg != {OFFSET_BITS{1'b1}}) begin
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
            end
            ST_ELEM: begin
                priority if (rd_byte == CH_DOT) begin
                    elem_done = 1'b1;
                    elem_ok   = 1'b1;
                    elem_next = j_reg + 1'b1;
                end else if (rd_byte == CH_LBRACK) begin
                    j_next     = j_reg + 1'b1;
                    neg_next   = 1'b0;
                    hit_next   = 1'b0;
                    state_next = ST_NEG;
                end else if (rd_byte == CH_BSLASH) begin
                    if ((j_reg + 1'b1) >= pat_len) begin
                        elem_done = 1'b1;
                        elem_ok   = 1'b0;
                        elem_next = pat_len;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_ESC;
                    end
                end else begin
                    elem_done = 1'b1;
                    elem_ok   = (rd_byte == b_reg);
                    elem_next = j_reg + 1'b1;
                end
            end
            ST_NEG: begin
                if ((j_reg < pat_len) && (rd_byte == CH_CARET)) begin
                    neg_next = 1'b1;
                    j_next   = j_reg + 1'b1;
                end
                state_next = ST_SET;
            end
            ST_SET: begin
                if ((j_reg < pat_len) && (rd_byte != CH_RBRACK)) begin
                    if (rd_byte == b_reg) begin
                        hit_next = 1'b1;
                    end
                    j_next = j_reg + 1'b1;
                end else begin
                    elem_done = 1'b1;
                    elem_ok   = neg_reg ^ hit_reg;
                    elem_next = (j_reg < pat_len) ? j_reg + 1'b1 : pat_len;
                end
            end
            ST_ESC: begin
                elem_done = 1'b1;
                elem_next = j_reg + 1'b1;
                priority if (rd_byte == CH_LOWER_A) begin
                    elem_ok = (b_reg >= CH_LOWER_A) && (b_reg <= CH_LOWER_Z);
                end else if (rd_byte == CH_UPPER_A) begin
                    elem_ok = (b_reg >= CH_UPPER_A) && (b_reg <= CH_UPPER_Z);
                end else begin
                    elem_ok = (rd_byte == b_reg);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (elem_done) begin
            if (elem_ok) begin
                cursor_next = elem_next;
            end else begin
                still_next = 1'b0;
            end
            state_next = ST_IDLE;
        end
    end

endmodule

FILE: verif/word_pattern_matcher_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_pattern_matcher_checker
// Watches the text, result and configuration channels of the word pattern
// matcher. It keeps its own copy of the pattern registers and the word
// scanning state, predicts the results that accepted text transactions
// cause and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module word_pattern_matcher_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [wpm_pkg::BYTE_W-1:0]     text_byte,
    input  logic                           end_of_text,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic                           found,
    input  logic [wpm_pkg::START_W-1:0]    word_start,
    input  logic [wpm_pkg::CUR_W-1:0]      word_length,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [wpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wpm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             pending,
    output int                             checked
);
    import wpm_pkg::*;

    localparam int PATTERN_WORDS = PATTERN_BYTES_DEF / 8;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic               found;
        logic [START_W-1:0] start;
        logic [CUR_W-1:0]   length;
    } match_result_t;

    logic [CFG_DATA_W-1:0]      pattern_words [PATTERN_WORDS];
    logic [CUR_W-1:0]           length_reg;
    logic [OFFSET_BITS_DEF-1:0] text_pos;
    logic [OFFSET_BITS_DEF-1:0] word_begin;
    logic [CUR_W-1:0]           word_len;
    logic [CUR_W-1:0]           cursor;
    logic                       still_fits;
    logic                       in_word;
    logic                       reported;
    match_result_t              expected_matches [$];
    match_result_t              want;
    int                         fail_total;
    int                         result_total;

    function automatic logic [7:0] pattern_at(input int k);
        if (k >= PATTERN_BYTES_DEF)
            return 8'h00;
        return pattern_words[k / 8][(k % 8) * 8 +: 8];
    endfunction

    function automatic int active_len();
        int n;
        n = int'(length_reg);
        return (n > PATTERN_BYTES_DEF) ? PATTERN_BYTES_DEF : n;
    endfunction

    function automatic logic element_accepts(input int c, input int len,
                                             input logic [7:0] b, output int nxt);
        logic [7:0] p;
        logic [7:0] x;
        int         j;
        logic       negated;
        logic       hit;
        p       = pattern_at(c);
        x       = 8'h00;
        j       = c + 1;
        negated = 1'b0;
        hit     = 1'b0;
        nxt     = c + 1;
        if (p == CH_DOT)
            return 1'b1;
        if (p == CH_LBRACK)
        begin
            if (j < len && pattern_at(j) == CH_CARET)
            begin
                negated = 1'b1;
                j++;
            end
            while (j < len && pattern_at(j) != CH_RBRACK)
            begin
                if (pattern_at(j) == b)
                    hit = 1'b1;
                j++;
            end
            nxt = (j < len) ? j + 1 : len;
            return negated ? !hit : hit;
        end
        if (p == CH_BSLASH)
        begin
            if (c + 1 >= len)
            begin
                nxt = len;
                return 1'b0;
            end
            x   = pattern_at(c + 1);
            nxt = c + 2;
            if (x == CH_LOWER_A)
                return (b >= CH_LOWER_A) && (b <= CH_LOWER_Z);
            if (x == CH_UPPER_A)
                return (b >= CH_UPPER_A) && (b <= CH_UPPER_Z);
            return x == b;
        end
        return p == b;
    endfunction

    function automatic logic word_complete();
        return in_word && still_fits && (int'(cursor) == active_len());
    endfunction

    function automatic void clear_text_state();
        text_pos   = '0;
        word_begin = '0;
        word_len   = '0;
        cursor     = '0;
        still_fits = 1'b1;
        in_word    = 1'b0;
        reported   = 1'b0;
    endfunction

    function automatic void scan_text_byte(input logic [7:0] b, input logic eot);
        int   len;
        int   nxt;
        logic blank;
        len   = active_len();
        nxt   = 0;
        blank = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
        if (eot)
        begin
            if (!reported)
            begin
                if (word_complete())
                    expected_matches.push_back({1'b1, word_begin[START_W-1:0], word_len});
                else
                    expected_matches.push_back({1'b0, {START_W{1'b0}}, {CUR_W{1'b0}}});
            end
            clear_text_state();
            return;
        end
        if (blank)
        begin
            if (in_word)
            begin
                if (!reported && word_complete())
                begin
                    expected_matches.push_back({1'b1, word_begin[START_W-1:0], word_len});
                    reported = 1'b1;
                end
                in_word = 1'b0;
            end
        end
        else
        begin
            if (!in_word)
            begin
                in_word    = 1'b1;
                word_begin = text_pos;
                word_len   = '0;
                cursor     = '0;
                still_fits = 1'b1;
            end
            if (word_len < WORD_LEN_MAX)
                word_len++;
            if (still_fits)
            begin
                if (int'(cursor) >= len || !element_accepts(int'(cursor), len, b, nxt))
                    still_fits = 1'b0;
                else
                    cursor = nxt[CUR_W-1:0];
            end
        end
        if (text_pos != '1)
            text_pos++;
    endfunction

    function automatic void note_failure(input string what);
        if (fail_total < REPORT_LIMIT)
            $display("[%0t] result %0d: %s", $realtime, result_total, what);
        fail_total++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (pattern_words[i])
                pattern_words[i] = '0;
            length_reg = '0;
            clear_text_state();
            expected_matches.delete();
            fail_total   = 0;
            result_total = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                result_total++;
                if (expected_matches.size() == 0)
                    note_failure($sformatf("no result expected, got found=%0d start=%0d length=%0d",
                                           found, word_start, word_length));
                else
                begin
                    want = expected_matches.pop_front();
                    if (found !== want.found || word_start !== want.start ||
                        word_length !== want.length)
                        note_failure($sformatf(
                            "expected found=%0d start=%0d length=%0d, got found=%0d start=%0d length=%0d",
                            want.found, want.start, want.length, found, word_start, word_length));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LEN_INDEX)
                    length_reg = cfg_data[CUR_W-1:0];
                else
                    pattern_words[cfg_index] = cfg_data;
            end
            if (in_valid && !in_stall)
                scan_text_byte(text_byte, end_of_text);
        end
        mismatches <= fail_total;
        pending    <= expected_matches.size();
        checked    <= result_total;
    end

endmodule

FILE: verif/word_pattern_matcher_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_pattern_matcher_top_test
// Loads patterns and streams text into the word pattern matcher: directed
// cases for every element kind and for corner cases, then random patterns with
// texts built from fitting, altered and noise words, under three idling
// mixes.
// ----------------------------------------------------------------------------
module word_pattern_matcher_top_test;
    import wpm_pkg::*;

    localparam int PATTERN_WORDS  = PATTERN_BYTES_DEF / 8;
    localparam int RANDOM_ITEMS   = 960;
    localparam int SETTLE_CYCLES  = 80;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum int {
        EL_ANY,
        EL_SET,
        EL_NOTSET,
        EL_LOWER,
        EL_UPPER,
        EL_ESCAPED,
        EL_LITERAL
    } elem_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [BYTE_W-1:0]     text_byte;
    logic                  end_of_text;
    logic                  out_valid;
    logic                  out_stall;
    logic                  found;
    logic [START_W-1:0]    word_start;
    logic [CUR_W-1:0]      word_length;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int pending;
    int checked;
    int send_idle;
    int recv_idle;
    int items_sent;
    int patterns_loaded;
    int quiet_cycles;

    elem_kind_t elem_kinds [$];
    logic [7:0] elem_chars [$];
    string      elem_sets [$];
    string      rand_pattern;
    logic [7:0] word_bytes [$];

    word_pattern_matcher_top i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .word_start  (word_start),
        .word_length (word_length),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    word_pattern_matcher_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .text_byte   (text_byte),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .found       (found),
        .word_start  (word_start),
        .word_length (word_length),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending),
        .checked     (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles.", WATCHDOG_LIMIT);
                $display("word_pattern_matcher_top test failed");
                $finish;
            end
        end
    end

    function automatic logic [7:0] solid_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR));
        return b;
    endfunction

    function automatic logic [7:0] blank_byte();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
    endfunction

    function automatic logic [7:0] pick_char(input string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    task automatic push_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        text_byte   <= b;
        end_of_text <= eot;
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
    endtask

    task automatic end_text();
        push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b0);
    endtask

    task automatic send_run(input logic [7:0] ch, input int count);
        repeat (count)
            push_byte(ch, 1'b0);
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // A negative length loads the string's own length.
    task automatic load_pattern(input string p, input int len);
        logic [CFG_DATA_W-1:0] data;
        int                    pos;
        for (int w = 0; w < PATTERN_WORDS; w++)
        begin
            data = {$urandom, $urandom};
            for (int k = 0; k < 8; k++)
            begin
                pos = w * 8 + k;
                if (pos < p.len())
                    data[k * 8 +: 8] = p[pos];
            end
            write_reg(w[CFG_IDX_W-1:0], data);
        end
        data = {$urandom, $urandom};
        data[CUR_W-1:0] = CUR_W'((len < 0) ? p.len() : len);
        write_reg(CFG_LEN_INDEX, data);
        patterns_loaded++;
    endtask

    task automatic make_random_pattern();
        int         count;
        elem_kind_t kind;
        string      piece;
        string      members;
        logic [7:0] ch;
        elem_kinds.delete();
        elem_chars.delete();
        elem_sets.delete();
        rand_pattern = "";
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
        repeat (count)
        begin
            kind    = elem_kind_t'($urandom_range(0, int'(EL_LITERAL)));
            members = "";
            ch      = 8'h00;
            case (kind)
                EL_ANY:     piece = ".";
                EL_SET, EL_NOTSET:
                begin
                    repeat ($urandom_range(0, 4))
                    begin
                        piece    = "a";
                        piece[0] = CH_LOWER_A + 8'($urandom_range(0, 9));
                        members  = {members, piece};
                    end
                    piece = (kind == EL_SET) ? {"[", members, "]"} : {"[^", members, "]"};
                end
                EL_LOWER:   piece = "\\a";
                EL_UPPER:   piece = "\\A";
                EL_ESCAPED:
                begin
                    ch       = pick_char("[].^\\*b0");
                    piece    = "\\x";
                    piece[1] = ch;
                end
                default:
                begin
                    ch       = pick_char("bcxyzQRW09]^-_#");
                    piece    = "x";
                    piece[0] = ch;
                end
            endcase
            if (rand_pattern.len() + piece.len() <= PATTERN_BYTES_DEF)
            begin
                rand_pattern = {rand_pattern, piece};
                elem_kinds.push_back(kind);
                elem_chars.push_back(ch);
                elem_sets.push_back(members);
            end
        end
    endtask

    task automatic make_fitting_word();
        string      members;
        logic [7:0] b;
        int         spot;
        word_bytes.delete();
        foreach (elem_kinds[i])
        begin
            members = elem_sets[i];
            case (elem_kinds[i])
                EL_ANY:     b = solid_byte();
                EL_SET:     b = (members.len() == 0) ? CH_LOWER_A : pick_char(members);
                EL_NOTSET:  b = CH_LOWER_A + 8'($urandom_range(10, 25));
                EL_LOWER:   b = CH_LOWER_A + 8'($urandom_range(0, 25));
                EL_UPPER:   b = CH_UPPER_A + 8'($urandom_range(0, 25));
                default:    b = elem_chars[i];
            endcase
            word_bytes.push_back(b);
        end
        case ($urandom_range(0, 9))
            0, 1:
            begin
                spot             = $urandom_range(0, word_bytes.size() - 1);
                word_bytes[spot] = solid_byte();
            end
            2:       word_bytes.push_back(solid_byte());
            3:       if (word_bytes.size() > 1) void'(word_bytes.pop_back());
            default: ;
        endcase
    endtask

    task automatic send_random_text();
        int words;
        int size;
        if ($urandom_range(0, 19) == 0)
        begin
            end_text();
            return;
        end
        if ($urandom_range(0, 3) == 0)
            push_byte(blank_byte(), 1'b0);
        words = $urandom_range(1, 5);
        for (int w = 0; w < words; w++)
        begin
            if ($urandom_range(0, 9) < 6)
                make_fitting_word();
            else
            begin
                word_bytes.delete();
                size = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 12);
                repeat (size)
                    word_bytes.push_back(solid_byte());
            end
            foreach (word_bytes[i])
                push_byte(word_bytes[i], 1'b0);
            if (w < words - 1 || $urandom_range(0, 2) != 0)
                repeat ($urandom_range(1, 3))
                    push_byte(blank_byte(), 1'b0);
        end
        end_text();
    endtask

    initial
    begin
        string pat;
        int    goal;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        text_byte    = '0;
        end_of_text  = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        send_idle    = 30;
        recv_idle    = 47;
        items_sent      = 0;
        patterns_loaded = 0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_chars("a b");
        end_text();
        end_text();

        quiesce();
        load_pattern("cat", -1);
        send_chars("dog cat cat\n");
        end_text();
        send_chars("xcat\tcat");
        end_text();

        quiesce();
        load_pattern(".[aeiou]\\a\\A\\.", -1);
        send_chars("ZZqQ. zeqQ.");
        end_text();

        quiesce();
        load_pattern("[^xyz]b", -1);
        send_chars("xb ab yb");
        end_text();

        quiesce();
        load_pattern("[]", -1);
        send_chars("a ] []");
        end_text();

        quiesce();
        load_pattern("[^]a", -1);
        push_byte(8'hFF, 1'b0);
        send_chars("a");
        end_text();

        quiesce();
        load_pattern("a[bc", -1);
        send_chars("ad ac");
        end_text();

        quiesce();
        load_pattern("ab\\", -1);
        send_chars("ab abx ab\\");
        end_text();

        quiesce();
        load_pattern("\\[\\]\\\\", -1);
        send_chars("[]\\ x");
        end_text();

        pat = "";
        repeat (PATTERN_BYTES_DEF)
            pat = {pat, "."};
        quiesce();
        load_pattern(pat, PATTERN_BYTES_DEF);
        send_run("q", 70);
        push_byte(CH_SPACE, 1'b0);
        send_run("Z", PATTERN_BYTES_DEF);
        end_text();

        quiesce();
        load_pattern(pat, 63);
        send_run("q", PATTERN_BYTES_DEF - 1);
        push_byte(CH_SPACE, 1'b0);
        send_run(8'h00, PATTERN_BYTES_DEF);
        end_text();

        quiesce();
        load_pattern("", 0);
        send_chars("x");
        end_text();

        quiesce();
        load_pattern("abcd", -1);
        send_chars("ab");
        quiesce();
        load_pattern("ab", -1);
        send_chars("c");
        end_text();

        quiesce();
        load_pattern("abcd", -1);
        send_chars("ab");
        quiesce();
        load_pattern("abxy", -1);
        send_chars("xy");
        end_text();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle = (phase == 0) ? 30 : (phase == 1) ? 47 : 0;
            recv_idle = (phase == 0) ? 47 : (phase == 1) ? 30 : 0;
            goal      = items_sent + RANDOM_ITEMS / 3;
            while (items_sent < goal)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    quiesce();
                    make_random_pattern();
                    case ($urandom_range(0, 11))
                        0:       load_pattern(rand_pattern, 0);
                        1:       load_pattern(rand_pattern, $urandom_range(rand_pattern.len(), 63));
                        default: load_pattern(rand_pattern, -1);
                    endcase
                end
                send_random_text();
            end
        end

        quiesce();
        $display("Sent %0d text transactions over %0d pattern loads: directed cases and random",
                 items_sent, patterns_loaded);
        $display("words under three idling mixes; %0d results compared.", checked);
        if (mismatches == 0 && pending == 0)
            $display("word_pattern_matcher_top test passed");
        else
            $display("word_pattern_matcher_top test failed");
        $finish;
    end

endmodule
